[hdl/cfh_pkg.sv]
// ----------------------------------------------------------------------------
// cfh_pkg: shared types and constants for the case-folding OAAT hash unit
// Mixing shifts, finalization shifts, fold range and hash floor.
// ----------------------------------------------------------------------------
package cfh_pkg;

  localparam int unsigned HashW = 32;
  localparam int unsigned ByteW = 8;

  localparam int unsigned MixShl    = 10;
  localparam int unsigned MixShr    = 6;
  localparam int unsigned FinShl1   = 3;
  localparam int unsigned FinShr    = 11;
  localparam int unsigned FinShl2   = 15;

  localparam logic [HashW-1:0] HashFloor = 32'd2;

  localparam logic [ByteW-1:0] FoldLo  = 8'h41;
  localparam logic [ByteW-1:0] FoldHi  = 8'h5A;
  localparam logic [ByteW-1:0] FoldAdd = 8'h20;

  // Mixed value handed from the mix stage to the finalizer.
  typedef struct packed {
    logic             valid;
    logic [HashW-1:0] hash;
  } mix_out_t;

  // ASCII upper case to lower case; everything else passes.
  function automatic logic [ByteW-1:0] fold_byte(input logic [ByteW-1:0] b);
    logic [ByteW-1:0] r;
    r = b;
    if (b >= FoldLo && b <= FoldHi) begin
      r = b + FoldAdd;
    end
    return r;
  endfunction

endpackage

[hdl/cfh_mix.sv]
// ----------------------------------------------------------------------------
// cfh_mix: input register and per-byte mixing stage
// Holds the running hash; hands the mixed value on for words marked last.
// ----------------------------------------------------------------------------
module cfh_mix (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [cfh_pkg::ByteW-1:0]     char_byte_i,
  input  logic                          byte_present_i,
  input  logic                          last_i,
  output cfh_pkg::mix_out_t             mix_o,
  input  logic                          mix_ready_i
);

  logic                          v_q;
  logic                          en_q;
  logic                          last_q;
  logic [cfh_pkg::ByteW-1:0]     byte_q;
  logic [cfh_pkg::HashW-1:0]     run_q;
  logic [cfh_pkg::HashW-1:0]     run_d;
  logic [cfh_pkg::HashW-1:0]     add_c;
  logic [cfh_pkg::HashW-1:0]     add_s;
  logic [cfh_pkg::HashW-1:0]     mixed;
  logic [cfh_pkg::HashW-1:0]     h_new;
  logic                          adv;

  // non-last words always drain; last words need room downstream
  assign adv        = v_q && (!last_q || mix_ready_i);
  assign in_ready_o = !v_q || adv;

  always_comb begin
    add_c = run_q + {{(cfh_pkg::HashW-cfh_pkg::ByteW){byte_q[cfh_pkg::ByteW-1]}}, byte_q};
    add_s = add_c + (add_c << cfh_pkg::MixShl);
    mixed = add_s ^ (add_s >> cfh_pkg::MixShr);
    h_new = en_q ? mixed : run_q;
    run_d = run_q;
    if (adv) begin
      run_d = last_q ? '0 : h_new;
    end
  end

  assign mix_o.valid = v_q && last_q;
  assign mix_o.hash  = h_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q   <= 1'b0;
      run_q <= '0;
    end else begin
      run_q <= run_d;
      if (in_ready_o) begin
        v_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      // a zero byte counts as no byte
      en_q   <= byte_present_i && (char_byte_i != '0);
      last_q <= last_i;
      byte_q <= cfh_pkg::fold_byte(char_byte_i);
    end
  end

endmodule

[hdl/cfh_final.sv]
// ----------------------------------------------------------------------------
// cfh_final: two-stage finalizer with output register
// First stage: add-shift-3 and xor-shift-11. Second: add-shift-15 and floor.
// ----------------------------------------------------------------------------
module cfh_final (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cfh_pkg::mix_out_t             mix_i,
  output logic                          mix_ready_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [cfh_pkg::HashW-1:0]     hash_value_o
);

  logic                          v1_q;
  logic [cfh_pkg::HashW-1:0]     h1_q;
  logic [cfh_pkg::HashW-1:0]     h1_d;
  logic [cfh_pkg::HashW-1:0]     a1;
  logic                          v2_q;
  logic [cfh_pkg::HashW-1:0]     h2_q;
  logic [cfh_pkg::HashW-1:0]     h2_d;
  logic [cfh_pkg::HashW-1:0]     a2;
  logic                          rdy2;
  logic                          rdy1;

  assign rdy2        = !v2_q || out_ready_i;
  assign rdy1        = !v1_q || rdy2;
  assign mix_ready_o = rdy1;

  always_comb begin
    a1   = mix_i.hash + (mix_i.hash << cfh_pkg::FinShl1);
    h1_d = a1 ^ (a1 >> cfh_pkg::FinShr);
    a2   = h1_q + (h1_q << cfh_pkg::FinShl2);
    h2_d = (a2 < cfh_pkg::HashFloor) ? a2 + cfh_pkg::HashFloor : a2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= mix_i.valid;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && mix_i.valid) begin
      h1_q <= h1_d;
    end
    if (rdy2 && v1_q) begin
      h2_q <= h2_d;
    end
  end

  assign out_valid_o  = v2_q;
  assign hash_value_o = h2_q;

endmodule

[hdl/case_folding_one_at_a_time_hash_unit.sv]
// ----------------------------------------------------------------------------
// case_folding_one_at_a_time_hash_unit: case-folding one-at-a-time hash
// Hashes one byte per word; emits the finalized hash for words marked last.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle unless a last word waits on a full finalizer;
//   the per-byte mix stage closes its loop combinationally on the running hash register.
// Path: a last word's hash goes from the edge that accepts it to the output
//   through the input register, the finalize stage and the output register.
// Reset: clears running hash and all stage valid bits; no result pending.
module case_folding_one_at_a_time_hash_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [cfh_pkg::ByteW-1:0]     char_byte_i,
  input  logic                          byte_present_i,
  input  logic                          last_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [cfh_pkg::HashW-1:0]     hash_value_o
);

  cfh_pkg::mix_out_t mix_s;
  logic              fin_ready;

  cfh_mix u_mix (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .char_byte_i    (char_byte_i),
    .byte_present_i (byte_present_i),
    .last_i         (last_i),
    .mix_o          (mix_s),
    .mix_ready_i    (fin_ready)
  );

  cfh_final u_final (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .mix_i        (mix_s),
    .mix_ready_o  (fin_ready),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .hash_value_o (hash_value_o)
  );

  a_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (hash_value_o >= cfh_pkg::HashFloor))
    else $error("hash below floor");

  // only a last word blocked by a full finalizer may stall the input
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (mix_s.valid && !fin_ready))
    else $error("input stalled without cause");

  a_mix_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mix_s.valid && !fin_ready) |=> (mix_s.valid && $stable(mix_s.hash)))
    else $error("mixed word lost while stalled");

endmodule

[tb/sv/case_folding_one_at_a_time_hash_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// case_folding_one_at_a_time_hash_unit_tb: self-checking bench for the OAAT hash
// Drives byte strings (directed corner cases, then random strings with noise)
// through the input channel. A local hash model predicts every finalized value.
// The output channel is checked in order while both sides idle at random.
// ----------------------------------------------------------------------------
module case_folding_one_at_a_time_hash_unit_tb;

  localparam int unsigned ClkPeriod   = 20;
  localparam int unsigned ResetCycles = 7;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned ItemsPerPhase = 375;
  localparam int unsigned LongHold    = 300;
  localparam int unsigned MaxReports  = 10;

  typedef logic [cfh_pkg::ByteW-1:0] char_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic [cfh_pkg::ByteW-1:0] char_byte_i;
  logic                      byte_present_i;
  logic                      last_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic [cfh_pkg::HashW-1:0] hash_value_o;

  case_folding_one_at_a_time_hash_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .char_byte_i    (char_byte_i),
    .byte_present_i (byte_present_i),
    .last_i         (last_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .hash_value_o   (hash_value_o)
  );

  // directed word: payload, plus a typed hash where one is obvious
  typedef struct packed {
    logic [cfh_pkg::ByteW-1:0] b;
    logic                      present;
    logic                      last;
    logic                      typed;
    logic [cfh_pkg::HashW-1:0] hash;
  } dir_word_t;

  localparam int unsigned NumDir = 21;
  dir_word_t dir_words [NumDir] = '{
    '{8'h00, 1'b0, 1'b1, 1'b1, 32'd2},   // empty string right after reset
    '{8'h37, 1'b0, 1'b0, 1'b0, 32'd0},   // idle word, byte ignored
    '{8'h00, 1'b1, 1'b1, 1'b1, 32'd2},   // present zero byte acts as none
    '{8'h41, 1'b1, 1'b0, 1'b0, 32'd0},
    '{8'h5A, 1'b1, 1'b0, 1'b0, 32'd0},
    '{8'h40, 1'b1, 1'b0, 1'b0, 32'd0},
    '{8'h5B, 1'b1, 1'b1, 1'b0, 32'd0},
    '{8'h61, 1'b1, 1'b0, 1'b0, 32'd0},
    '{8'h7A, 1'b1, 1'b1, 1'b0, 32'd0},
    '{8'h7F, 1'b1, 1'b0, 1'b0, 32'd0},
    '{8'h80, 1'b1, 1'b0, 1'b0, 32'd0},
    '{8'hFF, 1'b1, 1'b0, 1'b0, 32'd0},
    '{8'h00, 1'b1, 1'b0, 1'b0, 32'd0},   // zero byte mid string
    '{8'h00, 1'b0, 1'b1, 1'b0, 32'd0},   // byte-less last ends the string
    '{8'h00, 1'b0, 1'b1, 1'b1, 32'd2},
    '{8'h01, 1'b1, 1'b1, 1'b0, 32'd0},
    '{8'hAA, 1'b1, 1'b1, 1'b0, 32'd0},
    '{8'h55, 1'b1, 1'b1, 1'b0, 32'd0},
    '{8'h60, 1'b1, 1'b0, 1'b0, 32'd0},
    '{8'h7B, 1'b1, 1'b0, 1'b0, 32'd0},
    '{8'hC1, 1'b1, 1'b1, 1'b0, 32'd0}    // high byte, no folding
  };

  logic [cfh_pkg::HashW-1:0] str_hash;
  logic [cfh_pkg::HashW-1:0] pending_hashes [$];
  int unsigned               mismatch_count;
  int unsigned               live_words;
  int unsigned               send_idle_pct;
  int unsigned               recv_stall_pct;
  int unsigned               hold_req;
  int unsigned               cycles;

  // ---------------------------------------------------------------- model --
  function automatic logic [cfh_pkg::HashW-1:0] fold_extend(
      input logic [cfh_pkg::ByteW-1:0] b);
    logic [cfh_pkg::ByteW-1:0] f;
    f = b;
    if (b >= cfh_pkg::FoldLo && b <= cfh_pkg::FoldHi) begin
      f = b + cfh_pkg::FoldAdd;
    end
    return {{(cfh_pkg::HashW-cfh_pkg::ByteW){f[cfh_pkg::ByteW-1]}}, f};
  endfunction

  function automatic logic [cfh_pkg::HashW-1:0] oaat_mix(
      input logic [cfh_pkg::HashW-1:0] h, input logic [cfh_pkg::HashW-1:0] c);
    logic [cfh_pkg::HashW-1:0] v;
    v = h + c;
    v = v + (v << cfh_pkg::MixShl);
    v = v ^ (v >> cfh_pkg::MixShr);
    return v;
  endfunction

  function automatic logic [cfh_pkg::HashW-1:0] oaat_finish(
      input logic [cfh_pkg::HashW-1:0] h);
    logic [cfh_pkg::HashW-1:0] v;
    v = h + (h << cfh_pkg::FinShl1);
    v = v ^ (v >> cfh_pkg::FinShr);
    v = v + (v << cfh_pkg::FinShl2);
    if (v < cfh_pkg::HashFloor) begin
      v = v + cfh_pkg::HashFloor;
    end
    return v;
  endfunction

  // advance the running hash by one word; returns 1 when a hash comes out
  function automatic logic oaat_take(input logic [cfh_pkg::ByteW-1:0] b,
                                     input logic present, input logic last,
                                     output logic [cfh_pkg::HashW-1:0] res);
    res = '0;
    if (present && b != '0) begin
      str_hash = oaat_mix(str_hash, fold_extend(b));
    end
    if (!last) begin
      return 1'b0;
    end
    res = oaat_finish(str_hash);
    str_hash = '0;
    return 1'b1;
  endfunction

  // ----------------------------------------------------------- clk / limit --
  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // --------------------------------------------------- receiver + checker --
  initial begin
    logic [cfh_pkg::HashW-1:0] want;
    int unsigned               hold_left;
    hold_left   = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (pending_hashes.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MaxReports) begin
            $display("%0t: unexpected hash word %h", $realtime, hash_value_o);
          end
        end else begin
          want = pending_hashes.pop_front();
          if (hash_value_o !== want) begin
            mismatch_count++;
            if (mismatch_count <= MaxReports) begin
              $display("%0t: hash_value exp %h got %h", $realtime, want, hash_value_o);
            end
          end
        end
      end
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // --------------------------------------------------------------- sender --
  // Entered at a rising edge; leaves valid high so back-to-back words need
  // no drop. Typed hashes replace the predicted one in the expected store.
  task automatic send_word(input logic [cfh_pkg::ByteW-1:0] b, input logic present,
                           input logic last, input logic typed = 1'b0,
                           input logic [cfh_pkg::HashW-1:0] typed_hash = '0);
    logic [cfh_pkg::HashW-1:0] res;
    logic                      got;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    char_byte_i    <= b;
    byte_present_i <= present;
    last_i         <= last;
    do @(posedge clk_i); while (!in_ready_o);
    got = oaat_take(b, present, last, res);
    if (got) begin
      pending_hashes.push_back(typed ? typed_hash : res);
    end
    if (last || (present && b != '0)) begin
      live_words++;
    end
  endtask

  task automatic drain_hashes();
    in_valid_i <= 1'b0;
    while (pending_hashes.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [cfh_pkg::ByteW-1:0] rand_char();
    case ($urandom_range(9))
      0, 1, 2: return cfh_pkg::FoldLo + char_t'($urandom_range(25));
      3, 4:    return 8'h61 + char_t'($urandom_range(25));
      5:       return 8'h80 + char_t'($urandom_range(127));
      6:       return char_t'($urandom_range(255));   // zero now and then
      default: return char_t'($urandom_range(255, 1));
    endcase
  endfunction

  // one string with random content; sometimes ended by a byte-less last word,
  // with idle noise words sprinkled in
  task automatic send_random_string(input int unsigned max_len);
    int unsigned len;
    logic        tail_last;
    len       = $urandom_range(max_len);
    tail_last = (len == 0) || ($urandom_range(3) == 0);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(15) == 0) begin
        send_word(char_t'($urandom), 1'b0, 1'b0);
      end
      send_word(rand_char(), 1'b1, (i == len - 1) && !tail_last);
    end
    if (tail_last) begin
      send_word(char_t'($urandom), 1'b0, 1'b1);
    end
  endtask

  task automatic random_phase(input int unsigned send_pct, input int unsigned recv_pct);
    int unsigned stop_at;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    stop_at        = live_words + ItemsPerPhase;
    while (live_words < stop_at) begin
      send_random_string(($urandom_range(19) == 0) ? 40 : 12);
    end
    drain_hashes();
  endtask

  // ----------------------------------------------------------------- main --
  initial begin
    str_hash       = '0;
    mismatch_count = 0;
    live_words     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 0;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    char_byte_i    = '0;
    byte_present_i = 1'b0;
    last_i         = 1'b0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_words[i]) begin
      send_word(dir_words[i].b, dir_words[i].present, dir_words[i].last,
                dir_words[i].typed, dir_words[i].hash);
    end
    drain_hashes();

    random_phase(0, 0);
    random_phase(54, 0);
    random_phase(0, 54);
    random_phase(18, 18);

    // receiver backs off for a long stretch while short strings keep coming
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = LongHold;
    for (int unsigned i = 0; i < 40; i++) begin
      send_random_string(2);
    end
    drain_hashes();

    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0 && pending_hashes.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
